FILE: sv/glb_pkg.sv
// Shared types and constants for the greedy line breaker.
// Used by greedy_line_breaker_core, its checker and the bench; no other dependencies.
package glb_pkg;

    // Default word/line index limit
    localparam int MAX_WORDS_DEF = 1024;

    // Field widths
    localparam int LEN_W   = 8;
    localparam int IDX_W   = 11;
    localparam int GAP_W   = 8;
    localparam int IDEAL_W = 4;
    localparam int COST_W  = 16;

    // Configuration port
    localparam int CFG_DATA_W = 8;

    typedef enum logic [0:0] {
        CFG_LINE_WIDTH = 1'b0,
        CFG_IDEAL_GAP  = 1'b1
    } t_cfg_index;

    // Register reset values
    localparam logic [LEN_W-1:0]   LINE_WIDTH_RST = 8'd80;
    localparam logic [IDEAL_W-1:0] IDEAL_GAP_RST  = 4'd1;

    // Largest gap count on one line
    localparam logic [GAP_W-1:0] GAP_MAX = 8'd255;

    // Radix-2 divider steps (one per quotient bit)
    localparam int DIV_STEPS = GAP_W;

    typedef struct packed {
        logic [LEN_W-1:0] word_length;
        logic             final_word;
    } t_glb_in;

    typedef struct packed {
        logic [IDX_W-1:0]  line_index;
        logic [IDX_W-1:0]  line_first_word;
        logic [IDX_W-1:0]  line_last_word;
        logic [GAP_W-1:0]  gap_width;
        logic [COST_W-1:0] deviation_cost;
        logic              paragraph_end;
    } t_glb_out;

endpackage

FILE: sv/greedy_line_breaker_core.sv
// A word that closes no line passes S_DECIDE and S_FIN before it is ready for a new request.
// Each gap/cost evaluation runs the shared radix-2 divider (load, 8 steps, multiply, pick).
// A contested word needs two, a final flush one more; emitting waits out any result stall.
// Throughput: one request at a time; the result register lets a new request in while
// a line waits to be taken. Reset (i_rst_n low, synchronous) clears the sequencer,
// the result valid flag and the paragraph state, and reloads the configuration defaults.
module greedy_line_breaker_core
    import glb_pkg::*;
#(
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // word requests
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_glb_in               i_in_word,
    // closed lines
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_glb_out              o_out_line,
    // configuration writes
    input  logic                  i_cfg_we,
    input  t_cfg_index            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW   = $clog2(MAX_WORDS + 1);
    localparam int DCW  = $clog2(DIV_STEPS);
    localparam logic [CW-1:0]  MAX_IDX  = CW'(MAX_WORDS);
    localparam logic [DCW-1:0] DIV_LAST = DCW'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_EV_START, S_DIV, S_MUL, S_PICK, S_EMIT, S_FIN
    } t_state;

    typedef enum logic [1:0] { EV_C0, EV_C1, EV_EMIT } t_purpose;
    typedef enum logic [1:0] { POST_OPEN, POST_CLOSE, POST_CLEAR } t_post;

    t_state   r_state;
    t_purpose r_purpose;
    t_post    r_post;

    // configuration
    logic [LEN_W-1:0]   r_lw;
    logic [IDEAL_W-1:0] r_ideal;

    // paragraph state
    logic [CW-1:0]    r_words;
    logic [CW-1:0]    r_lines;
    logic [CW-1:0]    r_first;
    logic [LEN_W-1:0] r_letters;
    logic [LEN_W-1:0] r_span;
    logic [GAP_W-1:0] r_gaps;
    logic             r_open;

    // current request
    logic [LEN_W-1:0] r_w;
    logic             r_fin;
    logic [CW-1:0]    r_idx;

    // shared evaluation unit
    logic [LEN_W-1:0]  r_ev_let;
    logic [GAP_W-1:0]  r_ev_gaps;
    logic [GAP_W-1:0]  r_rem;
    logic [GAP_W-1:0]  r_dq;
    logic [DCW-1:0]    r_cnt;
    logic [GAP_W-1:0]  r_g;
    logic [COST_W-1:0] r_cost;
    logic [GAP_W-1:0]  r_g0;
    logic [COST_W-1:0] r_c0;

    // pending line
    logic [CW-1:0]     r_em_last;
    logic [GAP_W-1:0]  r_em_g;
    logic [COST_W-1:0] r_em_cost;
    logic              r_em_end;

    // result register
    logic     r_out_valid;
    t_glb_out r_out;

    logic              in_acc;
    logic              slot_free;
    logic [CW-1:0]     idx_nx;
    logic [CW-1:0]     idx_m1;
    logic [CW-1:0]     lines_nx;
    logic [CW-1:0]     last_clamped;
    logic              gap_full;
    logic              fit_ideal;
    logic              no_fit_min;
    logic [LEN_W-1:0]  room;
    logic [GAP_W:0]    rem_sh;
    logic              sub_ok;
    logic [GAP_W-1:0]  rem_nx;
    logic [GAP_W-1:0]  quot;
    logic [GAP_W-1:0]  ideal_ext;
    logic [GAP_W-1:0]  dev;
    logic [COST_W-1:0] prod;
    logic [LEN_W-1:0]  letters_w;
    logic [GAP_W-1:0]  gaps_p1;

    // handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_line  = r_out;

    // index arithmetic, saturating at MAX_WORDS
    always_comb begin
        idx_nx       = (r_words < MAX_IDX) ? r_words + 1'b1 : MAX_IDX;
        idx_m1       = r_idx - 1'b1;
        lines_nx     = (r_lines < MAX_IDX) ? r_lines + 1'b1 : r_lines;
        last_clamped = (r_em_last < r_first) ? r_first : r_em_last;
    end

    // line-fit tests (all sums below 10 bits)
    always_comb begin
        gap_full   = (r_gaps == GAP_MAX);
        fit_ideal  = ({2'b00, r_span} + {6'b0, r_ideal} + {2'b00, r_w})
                     <= {2'b00, r_lw};
        no_fit_min = ({2'b00, r_letters} + {2'b00, r_w} + {2'b00, r_gaps} + 10'd1)
                     > {2'b00, r_lw};
        letters_w  = LEN_W'({1'b0, r_letters} + {1'b0, r_w});
        gaps_p1    = r_gaps + 1'b1;
    end

    // divider step, gap deviation and cost
    always_comb begin
        room      = (r_lw > r_ev_let) ? r_lw - r_ev_let : '0;
        rem_sh    = {r_rem, r_dq[GAP_W-1]};
        sub_ok    = (rem_sh >= {1'b0, r_ev_gaps});
        rem_nx    = sub_ok ? GAP_W'(rem_sh - {1'b0, r_ev_gaps}) : rem_sh[GAP_W-1:0];
        quot      = (r_ev_gaps == '0) ? '0 : r_dq;
        ideal_ext = {{(GAP_W-IDEAL_W){1'b0}}, r_ideal};
        dev       = (quot > ideal_ext) ? quot - ideal_ext : ideal_ext - quot;
        prod      = COST_W'(r_ev_gaps) * COST_W'(dev);
    end

    // sequencer, paragraph state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_lw        <= LINE_WIDTH_RST;
            r_ideal     <= IDEAL_GAP_RST;
            r_words     <= '0;
            r_lines     <= '0;
            r_first     <= '0;
            r_letters   <= '0;
            r_span      <= '0;
            r_gaps      <= '0;
            r_open      <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LINE_WIDTH: r_lw    <= i_cfg_data[LEN_W-1:0];
                    CFG_IDEAL_GAP:  r_ideal <= i_cfg_data[IDEAL_W-1:0];
                    default: ;
                endcase
            end

            // line taken; S_EMIT reloads the register itself
            if (r_out_valid && !i_out_stall && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_w     <= i_in_word.word_length;
                        r_fin   <= i_in_word.final_word;
                        r_idx   <= idx_nx;
                        r_words <= idx_nx;
                        r_state <= S_DECIDE;
                    end
                end

                S_DECIDE: begin
                    if (!r_open) begin
                        // start a new line
                        r_first   <= r_idx;
                        r_letters <= r_w;
                        r_span    <= r_w;
                        r_gaps    <= '0;
                        r_open    <= 1'b1;
                        r_state   <= S_FIN;
                    end else if (!gap_full && fit_ideal) begin
                        // fits at the preferred gap
                        r_span    <= LEN_W'({2'b00, r_span} + {6'b0, r_ideal} + {2'b00, r_w});
                        r_letters <= letters_w;
                        r_gaps    <= gaps_p1;
                        r_state   <= S_FIN;
                    end else if (gap_full || no_fit_min) begin
                        // cannot fit at all: close before the word
                        r_ev_let  <= r_letters;
                        r_ev_gaps <= r_gaps;
                        r_em_last <= idx_m1;
                        r_em_end  <= 1'b0;
                        r_post    <= POST_OPEN;
                        r_purpose <= EV_EMIT;
                        r_state   <= S_EV_START;
                    end else begin
                        // contested: compare cost without and with the word
                        r_ev_let  <= r_letters;
                        r_ev_gaps <= r_gaps;
                        r_purpose <= EV_C0;
                        r_state   <= S_EV_START;
                    end
                end

                S_EV_START: begin
                    r_rem   <= '0;
                    r_dq    <= room;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end

                // restoring division, one quotient bit a cycle
                S_DIV: begin
                    r_rem <= rem_nx;
                    r_dq  <= {r_dq[GAP_W-2:0], sub_ok};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_MUL;
                    end
                end

                S_MUL: begin
                    r_g     <= quot;
                    r_cost  <= prod;
                    r_state <= S_PICK;
                end

                S_PICK: begin
                    case (r_purpose)
                        EV_C0: begin
                            r_c0      <= r_cost;
                            r_g0      <= r_g;
                            r_ev_let  <= letters_w;
                            r_ev_gaps <= gaps_p1;
                            r_purpose <= EV_C1;
                            r_state   <= S_EV_START;
                        end
                        EV_C1: begin
                            if (r_c0 >= r_cost) begin
                                // take the word, close after it
                                r_em_g    <= r_g;
                                r_em_cost <= r_cost;
                                r_em_last <= r_idx;
                                r_em_end  <= r_fin;
                                r_post    <= POST_CLOSE;
                            end else begin
                                r_em_g    <= r_g0;
                                r_em_cost <= r_c0;
                                r_em_last <= idx_m1;
                                r_em_end  <= 1'b0;
                                r_post    <= POST_OPEN;
                            end
                            r_state <= S_EMIT;
                        end
                        EV_EMIT: begin
                            r_em_g    <= r_g;
                            r_em_cost <= r_cost;
                            r_state   <= S_EMIT;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end

                // hand the closed line to the result register
                S_EMIT: begin
                    if (slot_free) begin
                        r_out_valid                <= 1'b1;
                        r_out.line_index           <= IDX_W'(lines_nx);
                        r_out.line_first_word      <= IDX_W'(r_first);
                        r_out.line_last_word       <= IDX_W'(last_clamped);
                        r_out.gap_width            <= r_em_g;
                        r_out.deviation_cost       <= r_em_cost;
                        r_out.paragraph_end        <= r_em_end;
                        case (r_post)
                            POST_OPEN: begin
                                r_lines   <= lines_nx;
                                r_first   <= r_idx;
                                r_letters <= r_w;
                                r_span    <= r_w;
                                r_gaps    <= '0;
                                r_open    <= 1'b1;
                                r_state   <= S_FIN;
                            end
                            POST_CLOSE: begin
                                r_lines <= lines_nx;
                                r_open  <= 1'b0;
                                r_state <= S_FIN;
                            end
                            POST_CLEAR: begin
                                r_words   <= '0;
                                r_lines   <= '0;
                                r_first   <= '0;
                                r_letters <= '0;
                                r_span    <= '0;
                                r_gaps    <= '0;
                                r_open    <= 1'b0;
                                r_state   <= S_IDLE;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end

                // paragraph end: flush the open line, or just clear
                S_FIN: begin
                    if (r_fin && r_open) begin
                        r_ev_let  <= r_letters;
                        r_ev_gaps <= r_gaps;
                        r_em_last <= r_idx;
                        r_em_end  <= 1'b1;
                        r_post    <= POST_CLEAR;
                        r_purpose <= EV_EMIT;
                        r_state   <= S_EV_START;
                    end else begin
                        if (r_fin) begin
                            r_words   <= '0;
                            r_lines   <= '0;
                            r_first   <= '0;
                            r_letters <= '0;
                            r_span    <= '0;
                            r_gaps    <= '0;
                            r_open    <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/glb_checker.sv
// Port-level checks for greedy_line_breaker_core, bound into every instance of that module.
// Depends on glb_pkg.
module glb_checker
    import glb_pkg::*;
#(
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_glb_out o_out_line
);

    localparam bit SMALL_IDX = (MAX_WORDS < 2048);

    // one request at a time: busy right after a request is taken
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while the previous one is in progress");

    // a stalled line is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_line))
        else $error("stalled line changed or dropped");

    // last word never before first word
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && SMALL_IDX |->
            o_out_line.line_last_word >= o_out_line.line_first_word)
        else $error("line ends before it starts");

    // a single-word line has no gaps, so no gap width and no cost
    // (indices near saturation can repeat, so those lines are left out)
    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && SMALL_IDX &&
        o_out_line.line_first_word == o_out_line.line_last_word &&
        o_out_line.line_last_word < IDX_W'(MAX_WORDS - 1) |->
            o_out_line.gap_width == '0 && o_out_line.deviation_cost == '0)
        else $error("single-word line with non-zero gap or cost");

endmodule

bind greedy_line_breaker_core glb_checker #(.MAX_WORDS(MAX_WORDS)) u_glb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_line  (o_out_line)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for greedy_line_breaker_core: drives word requests, predicts every
// closed line in SystemVerilog and checks the lines that come out. Depends on glb_pkg.
module tb;
    import glb_pkg::*;

    localparam int IDX_LIMIT     = MAX_WORDS_DEF;
    localparam int SETTLE_CYCLES = 64;
    localparam int TIMEOUT_NS    = 10_000_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  o_in_stall;
    t_glb_in               in_word = '0;
    logic                  o_out_valid;
    logic                  out_stall = 1'b0;
    t_glb_out              o_out_line;
    logic                  cfg_we = 1'b0;
    t_cfg_index            cfg_index = CFG_LINE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    greedy_line_breaker_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_line  (o_out_line),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Pending word requests and the lines they are expected to close
    t_glb_in  word_q[$];
    t_glb_out line_q[$];

    // Idling controls, per phase
    bit src_idle_en = 1'b1;
    bit snk_idle_en = 1'b1;
    int hold_left   = 0;
    int stall_left  = 0;

    // Run statistics
    int n_bad       = 0;
    int n_taken     = 0;
    int n_lines_got = 0;
    int n_paras     = 0;
    int n_writes    = 0;

    // Predictor: configuration copy and paragraph state
    int unsigned cfg_width = LINE_WIDTH_RST;
    int unsigned cfg_gap   = IDEAL_GAP_RST;
    int unsigned n_words    = 0;
    int unsigned n_lines    = 0;
    int unsigned first_word = 0;
    int unsigned letters    = 0;
    int unsigned span       = 0;
    int unsigned n_gaps     = 0;
    bit          line_live  = 1'b0;

    // Stretched gap: free room over gaps, room clamped at zero
    function automatic int unsigned gap_for(int unsigned lt, int unsigned gp);
        int unsigned room;
        if (gp == 0) return 0;
        room = (cfg_width > lt) ? cfg_width - lt : 0;
        return room / gp;
    endfunction

    function automatic int unsigned cost_for(int unsigned lt, int unsigned gp);
        int unsigned g;
        int unsigned d;
        g = gap_for(lt, gp);
        d = (g > cfg_gap) ? g - cfg_gap : cfg_gap - g;
        return gp * d;
    endfunction

    function automatic t_glb_out close_line(int unsigned last_idx, int unsigned lt,
                                            int unsigned gp);
        t_glb_out r;
        if (n_lines < IDX_LIMIT) n_lines++;
        if (last_idx < first_word) last_idx = first_word;
        r.line_index      = IDX_W'(n_lines);
        r.line_first_word = IDX_W'(first_word);
        r.line_last_word  = IDX_W'(last_idx);
        r.gap_width       = GAP_W'(gap_for(lt, gp));
        r.deviation_cost  = COST_W'(cost_for(lt, gp));
        r.paragraph_end   = 1'b0;
        return r;
    endfunction

    function automatic void open_line(int unsigned idx, int unsigned w);
        first_word = idx;
        letters    = w;
        span       = w;
        n_gaps     = 0;
        line_live  = 1'b1;
    endfunction

    // Greedy break of one word: queues the lines it closes
    function automatic void break_word(t_glb_in req);
        int unsigned w;
        int unsigned idx;
        t_glb_out    lines[2];
        int          n;
        w   = req.word_length;
        n   = 0;
        idx = (n_words < IDX_LIMIT) ? n_words + 1 : IDX_LIMIT;
        n_words = idx;
        if (!line_live) begin
            open_line(idx, w);
        end else if (n_gaps < GAP_MAX && span + cfg_gap + w <= cfg_width) begin
            span    = (span + cfg_gap + w) & 32'hFFFF;
            letters = (letters + w) & 32'hFFFF;
            n_gaps++;
        end else if (n_gaps >= GAP_MAX || letters + w + n_gaps + 1 > cfg_width) begin
            lines[n] = close_line(idx - 1, letters, n_gaps);
            n++;
            open_line(idx, w);
        end else if (cost_for(letters, n_gaps) >= cost_for(letters + w, n_gaps + 1)) begin
            // stretched line is no worse: take the word and close
            lines[n] = close_line(idx, letters + w, n_gaps + 1);
            n++;
            line_live = 1'b0;
        end else begin
            lines[n] = close_line(idx - 1, letters, n_gaps);
            n++;
            open_line(idx, w);
        end
        // last word flushes the paragraph
        if (req.final_word) begin
            if (line_live) begin
                lines[n] = close_line(idx, letters, n_gaps);
                n++;
            end
            lines[n-1].paragraph_end = 1'b1;
            n_words    = 0;
            n_lines    = 0;
            first_word = 0;
            letters    = 0;
            span       = 0;
            n_gaps     = 0;
            line_live  = 1'b0;
        end
        for (int k = 0; k < n; k++) line_q.push_back(lines[k]);
    endfunction

    // Word request driver with random hold-off bursts
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                break_word(in_word);
                n_taken++;
            end
            if (!in_valid || !o_in_stall) begin
                if (hold_left > 0) begin
                    hold_left--;
                    in_valid <= 1'b0;
                end else if (word_q.size() > 0) begin
                    if (src_idle_en && $urandom_range(0, 5) == 0) begin
                        hold_left = $urandom_range(0, 16);
                        in_valid <= 1'b0;
                    end else begin
                        in_word  <= word_q.pop_front();
                        in_valid <= 1'b1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Line monitor: field-by-field check against the oldest prediction
    always @(posedge i_clk) begin : watch_lines
        t_glb_out want;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                n_lines_got++;
                if (line_q.size() == 0) begin
                    $error("line %0d arrived with none predicted", o_out_line.line_index);
                    n_bad++;
                end else begin
                    want = line_q.pop_front();
                    if (o_out_line.line_index !== want.line_index) begin
                        $error("line_index: expected %0d, got %0d",
                               want.line_index, o_out_line.line_index);
                        n_bad++;
                    end
                    if (o_out_line.line_first_word !== want.line_first_word) begin
                        $error("line_first_word: expected %0d, got %0d",
                               want.line_first_word, o_out_line.line_first_word);
                        n_bad++;
                    end
                    if (o_out_line.line_last_word !== want.line_last_word) begin
                        $error("line_last_word: expected %0d, got %0d",
                               want.line_last_word, o_out_line.line_last_word);
                        n_bad++;
                    end
                    if (o_out_line.gap_width !== want.gap_width) begin
                        $error("gap_width: expected %0d, got %0d",
                               want.gap_width, o_out_line.gap_width);
                        n_bad++;
                    end
                    if (o_out_line.deviation_cost !== want.deviation_cost) begin
                        $error("deviation_cost: expected %0d, got %0d",
                               want.deviation_cost, o_out_line.deviation_cost);
                        n_bad++;
                    end
                    if (o_out_line.paragraph_end !== want.paragraph_end) begin
                        $error("paragraph_end: expected %0d, got %0d",
                               want.paragraph_end, o_out_line.paragraph_end);
                        n_bad++;
                    end
                end
            end
            // result-side stall bursts
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 16);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send(input int unsigned len, input bit last_word);
        t_glb_in req;
        req.word_length = LEN_W'(len);
        req.final_word  = last_word;
        word_q.push_back(req);
        if (last_word) n_paras++;
    endtask

    // Wait until every request is taken and every line has come, then let the core go idle
    task automatic settle();
        while (word_q.size() != 0 || in_valid || line_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_LINE_WIDTH) cfg_width = data;
        else cfg_gap = data[IDEAL_W-1:0];
        n_writes++;
    endtask

    // One random phase: new settings (the open paragraph carries over), then words
    task automatic random_phase(input bit calm);
        int unsigned lw;
        int unsigned hi;
        int unsigned len;
        int          count;
        int          pick;
        logic [CFG_DATA_W-1:0] gd;
        settle();
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 5);
            case (pick)
                0:       lw = 255;
                1:       lw = $urandom_range(0, 2);
                2, 3:    lw = $urandom_range(10, 40);
                default: lw = $urandom_range(1, 255);
            endcase
            write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(lw));
        end
        if ($urandom_range(0, 3) != 0) begin
            gd = CFG_DATA_W'($urandom);
            pick = $urandom_range(0, 4);
            case (pick)
                0:       gd[IDEAL_W-1:0] = '0;
                1:       gd[IDEAL_W-1:0] = '1;
                default: gd[IDEAL_W-1:0] = IDEAL_W'($urandom_range(1, 6));
            endcase
            write_reg(CFG_IDEAL_GAP, gd);
        end
        src_idle_en = !calm && $urandom_range(0, 3) != 0;
        snk_idle_en = !calm && $urandom_range(0, 3) != 0;
        hi    = (cfg_width > 8) ? cfg_width / 3 : 3;
        count = $urandom_range(30, 50);
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 19);
            case (pick)
                0:       len = 0;
                1:       len = 255;
                2, 3:    len = $urandom_range(0, 255);
                default: len = $urandom_range(1, hi);
            endcase
            send(len, $urandom_range(0, 11) == 0);
        end
    endtask

    // Stimulus
    initial begin
        while (!i_rst_n) @(posedge i_clk);

        // Reset settings: single-word paragraph, zero and widest words
        send(255, 1);
        send(0, 0);
        send(1, 0);
        send(255, 0);
        send(79, 1);

        // Narrow line: stretched join refused, no fit, stretched join taken, lone flush
        settle();
        write_reg(CFG_LINE_WIDTH, 8'd20);
        write_reg(CFG_IDEAL_GAP, 8'hA2);
        send(5, 0);
        send(5, 0);
        send(5, 0);
        send(2, 0);
        send(4, 0);
        send(9, 0);
        send(3, 0);
        send(4, 0);
        send(11, 0);
        send(7, 1);

        // Widest line, largest ideal gap
        settle();
        write_reg(CFG_LINE_WIDTH, 8'hFF);
        write_reg(CFG_IDEAL_GAP, 8'h0F);
        send(120, 0);
        send(120, 0);
        send(1, 1);

        // Gap count full: zero ideal gap and empty words
        settle();
        write_reg(CFG_LINE_WIDTH, 8'd200);
        write_reg(CFG_IDEAL_GAP, 8'hF0);
        for (int k = 0; k < 260; k++) send(0, 0);
        send(0, 1);

        for (int p = 0; p < 5; p++) random_phase(1'b0);

        // One long paragraph, a line per word: word and line indices saturate
        settle();
        write_reg(CFG_LINE_WIDTH, 8'd4);
        write_reg(CFG_IDEAL_GAP, 8'd1);
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        for (int k = 0; k < 1030; k++) send($urandom_range(5, 255), 1'b0);
        send($urandom_range(5, 255), 1'b1);

        for (int p = 0; p < 5; p++) random_phase(1'b0);
        for (int p = 0; p < 2; p++) random_phase(1'b1);

        settle();
        $display("Run took %0d words in %0d+ paragraphs and checked %0d lines",
                 n_taken, n_paras, n_lines_got);
        $display("across %0d register writes, gap-full and saturated-index paragraphs included",
                 n_writes);
        if (n_bad == 0 && line_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
sv/glb_pkg.sv
sv/greedy_line_breaker_core.sv
sv/glb_checker.sv
tb/tb.sv
